/* design/scan_point_to_world_transform_macros.svh */
// assertion macros shared by the checker
`ifndef SCAN_POINT_TO_WORLD_TRANSFORM_MACROS_SVH
`define SCAN_POINT_TO_WORLD_TRANSFORM_MACROS_SVH

// implication checked on every clock edge outside reset
`define SPWT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spwt implication check failed");

// condition that must hold on every clock edge outside reset
`define SPWT_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("spwt invariant check failed");

`endif

/* design/spwt_pkg.sv */
package spwt_pkg;

    localparam int XW = 34;             // cordic x and y width
    localparam int ZW = 32;             // residual angle, 2^-32 turn units
    localparam int RW = XW - 14 + 1;    // rounded and rotated component width
    localparam int SW = 33;             // pose sum before saturation
    localparam int ATAN_ENTRIES = 24;

    localparam logic [31:0] GAIN_INV = 32'd2608131496;
    localparam logic [15:0] HALF_QUADRANT = 16'd8192;
    localparam logic signed [XW-1:0] ROUND_BIAS = XW'(8192);

    localparam logic [31:0] ATAN_TABLE [0:ATAN_ENTRIES-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    localparam logic [1:0] QUAD_ZERO  = 2'd0;
    localparam logic [1:0] QUAD_ONE   = 2'd1;
    localparam logic [1:0] QUAD_TWO   = 2'd2;
    localparam logic [1:0] QUAD_THREE = 2'd3;

    localparam logic [2:0] REG_POSE_X       = 3'd0;
    localparam logic [2:0] REG_POSE_Y       = 3'd1;
    localparam logic [2:0] REG_POSE_HEADING = 3'd2;
    localparam logic [2:0] REG_RANGE_LOWER  = 3'd3;
    localparam logic [2:0] REG_RANGE_UPPER  = 3'd4;

    typedef struct packed {
        logic                 keep;
        logic                 scan_end;
        logic [1:0]           quad;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } stage_t;

endpackage

/* design/spwt_pre.sv */
module spwt_pre
    import spwt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_in,
    input  logic        [15:0] beam_range,
    input  logic signed [15:0] beam_angle,
    input  logic               scan_end,
    input  logic        [15:0] pose_heading,
    input  logic        [15:0] range_lower,
    input  logic        [15:0] range_upper,
    output logic               valid_out,
    output stage_t             stage_out
);

    logic         valid_reg;
    stage_t       stage_reg;
    stage_t       stage_next;
    logic [15:0]  turn;
    logic [15:0]  shifted;
    logic [1:0]   quad;
    logic [15:0]  resid;
    logic [47:0]  prod;

    always_comb
    begin
        turn    = 16'(beam_angle) + pose_heading;
        shifted = turn + HALF_QUADRANT;
        quad    = shifted[15:14];
        // residual angle lands in [-8192, 8191] as a signed value
        resid   = turn - {quad, 14'd0};
        prod    = 48'(beam_range) * 48'(GAIN_INV);

        stage_next.keep     = (beam_range >= range_lower) && (beam_range <= range_upper);
        stage_next.scan_end = scan_end;
        stage_next.quad     = quad;
        stage_next.x        = signed'({{(XW - 30){1'b0}}, prod[47:18]});
        stage_next.y        = '0;
        stage_next.z        = signed'({resid, 16'd0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign valid_out = valid_reg;
    assign stage_out = stage_reg;

endmodule

/* design/spwt_cell.sv */
module spwt_cell
    import spwt_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   valid_in,
    input  stage_t stage_in,
    output logic   valid_out,
    output stage_t stage_out
);

    localparam logic signed [ZW-1:0] ATAN_STEP = signed'(ATAN_TABLE[STAGE]);

    logic                 valid_reg;
    stage_t               stage_reg;
    stage_t               stage_next;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    always_comb
    begin
        dx = stage_in.y >>> STAGE;
        dy = stage_in.x >>> STAGE;
        stage_next = stage_in;
        // rotate toward zero residual angle
        if (!stage_in.z[ZW-1])
        begin
            stage_next.x = stage_in.x - dx;
            stage_next.y = stage_in.y + dy;
            stage_next.z = stage_in.z - ATAN_STEP;
        end
        else
        begin
            stage_next.x = stage_in.x + dx;
            stage_next.y = stage_in.y - dy;
            stage_next.z = stage_in.z + ATAN_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign valid_out = valid_reg;
    assign stage_out = stage_reg;

endmodule

/* design/spwt_post.sv */
module spwt_post
    import spwt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_in,
    input  stage_t             stage_in,
    input  logic signed [31:0] pose_x,
    input  logic signed [31:0] pose_y,
    output logic               done,
    output logic               keep,
    output logic signed [31:0] world_x,
    output logic signed [31:0] world_y,
    output logic               scan_end_out
);

    logic                 rot_valid_reg;
    logic                 rot_keep_reg;
    logic                 rot_end_reg;
    logic signed [RW-1:0] rot_x_reg;
    logic signed [RW-1:0] rot_y_reg;
    logic signed [RW-1:0] rot_x_next;
    logic signed [RW-1:0] rot_y_next;
    logic signed [XW-1:0] rnd_x;
    logic signed [XW-1:0] rnd_y;
    logic signed [RW-1:0] px;
    logic signed [RW-1:0] py;

    logic                 done_reg;
    logic                 keep_reg;
    logic                 end_reg;
    logic signed [31:0]   world_x_reg;
    logic signed [31:0]   world_y_reg;
    logic signed [31:0]   world_x_next;
    logic signed [31:0]   world_y_next;
    logic signed [SW-1:0] sum_x;
    logic signed [SW-1:0] sum_y;

    function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
        logic signed [31:0] r;
        if (!v[SW-1] && v[SW-2])
            r = 32'sh7FFFFFFF;
        else if (v[SW-1] && !v[SW-2])
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // round to 1/1024 m, then undo the quadrant fold exactly
    always_comb
    begin
        rnd_x = stage_in.x + ROUND_BIAS;
        rnd_y = stage_in.y + ROUND_BIAS;
        px    = RW'(signed'(rnd_x[XW-1:14]));
        py    = RW'(signed'(rnd_y[XW-1:14]));
        case (stage_in.quad)
            QUAD_ZERO:
            begin
                rot_x_next = px;
                rot_y_next = py;
            end
            QUAD_ONE:
            begin
                rot_x_next = -py;
                rot_y_next = px;
            end
            QUAD_TWO:
            begin
                rot_x_next = -px;
                rot_y_next = -py;
            end
            default:
            begin
                rot_x_next = py;
                rot_y_next = -px;
            end
        endcase
    end

    always_comb
    begin
        sum_x = SW'(rot_x_reg) + SW'(pose_x);
        sum_y = SW'(rot_y_reg) + SW'(pose_y);
        world_x_next = rot_keep_reg ? sat32(sum_x) : '0;
        world_y_next = rot_keep_reg ? sat32(sum_y) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            rot_valid_reg <= valid_in;
            done_reg      <= rot_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rot_keep_reg <= stage_in.keep;
        rot_end_reg  <= stage_in.scan_end;
        rot_x_reg    <= rot_x_next;
        rot_y_reg    <= rot_y_next;
        keep_reg     <= rot_keep_reg;
        end_reg      <= rot_end_reg;
        world_x_reg  <= world_x_next;
        world_y_reg  <= world_y_next;
    end

    assign done         = done_reg;
    assign keep         = keep_reg;
    assign world_x      = world_x_reg;
    assign world_y      = world_y_reg;
    assign scan_end_out = end_reg;

endmodule

/* design/scan_point_to_world_transform.sv */
// Converts one lidar beam (range, angle) per clock into a world point, offset by the
// configured robot pose. busy stays low: an item is taken on every cycle that start is
// high. Its result is registered through one input stage with the range scaling multiply,
// one cell per CORDIC iteration (at most ATAN_ENTRIES cells), a rounding stage and a pose
// offset stage, and appears in the cycle that the done strobe is high. The result is
// shown for that single cycle only, so the receiver must capture it then. Pose and range
// limits should be written only while no beam is in flight.
module scan_point_to_world_transform
    import spwt_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic        [15:0] beam_range,
    input  logic signed [15:0] beam_angle,
    input  logic               scan_end,
    output logic               done,
    output logic               keep,
    output logic signed [31:0] world_x,
    output logic signed [31:0] world_y,
    output logic               scan_end_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [2:0]  cfg_index,
    input  logic        [31:0] cfg_data
);

    localparam int RUN = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

    logic signed [31:0] pose_x_reg;
    logic signed [31:0] pose_y_reg;
    logic        [15:0] pose_heading_reg;
    logic        [15:0] range_lower_reg;
    logic        [15:0] range_upper_reg;

    logic   chain_valid [0:RUN];
    stage_t chain_stage [0:RUN];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_x_reg       <= '0;
            pose_y_reg       <= '0;
            pose_heading_reg <= '0;
            range_lower_reg  <= '0;
            range_upper_reg  <= 16'hFFFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_POSE_X:       pose_x_reg       <= signed'(cfg_data);
                REG_POSE_Y:       pose_y_reg       <= signed'(cfg_data);
                REG_POSE_HEADING: pose_heading_reg <= cfg_data[15:0];
                REG_RANGE_LOWER:  range_lower_reg  <= cfg_data[15:0];
                REG_RANGE_UPPER:  range_upper_reg  <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    spwt_pre u_pre (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid_in     (start && !busy),
        .beam_range   (beam_range),
        .beam_angle   (beam_angle),
        .scan_end     (scan_end),
        .pose_heading (pose_heading_reg),
        .range_lower  (range_lower_reg),
        .range_upper  (range_upper_reg),
        .valid_out    (chain_valid[0]),
        .stage_out    (chain_stage[0])
    );

    for (genvar i = 0; i < RUN; i++)
    begin : g_cell
        spwt_cell #(
            .STAGE (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (chain_valid[i]),
            .stage_in  (chain_stage[i]),
            .valid_out (chain_valid[i+1]),
            .stage_out (chain_stage[i+1])
        );
    end

    spwt_post u_post (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid_in     (chain_valid[RUN]),
        .stage_in     (chain_stage[RUN]),
        .pose_x       (pose_x_reg),
        .pose_y       (pose_y_reg),
        .done         (done),
        .keep         (keep),
        .world_x      (world_x),
        .world_y      (world_y),
        .scan_end_out (scan_end_out)
    );

endmodule

/* design/spwt_checker.sv */
`include "scan_point_to_world_transform_macros.svh"

module spwt_checker
#(
    parameter int CORDIC_STAGES = 16
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic               keep,
    input logic signed [31:0] world_x,
    input logic signed [31:0] world_y
);

    localparam int RUN = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
    localparam int LATENCY = RUN + 3;

    // every accepted item comes out after the fixed pipeline depth
    `SPWT_ASSERT_IMPLY(a_latency, clk, rst_n, start && !busy, ##LATENCY done)

    // a dropped beam reports the origin
    `SPWT_ASSERT_IMPLY(a_drop_zero, clk, rst_n, done && !keep, world_x == 0 && world_y == 0)

    // the pipeline never stalls the sender
    `SPWT_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)

endmodule

bind scan_point_to_world_transform spwt_checker #(
    .CORDIC_STAGES (CORDIC_STAGES)
) u_spwt_checker (.*);
